[sv/jcs_pkg.sv]
// jcs_pkg: shared constants, codes and types for the joystick calibration sequencer.
// Used by jcs_front, jcs_queue, jcs_back and joystick_calibration_sequencer.
package jcs_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int CENTER_SAMPLES = 8;
  localparam int CNT_W          = $clog2(CENTER_SAMPLES + 1);
  localparam int SUM_W          = SAMPLE_BITS + $clog2(CENTER_SAMPLES);
  localparam int NUM_CH         = 4;
  localparam int CH_W           = 2;
  localparam int DB_W           = 8;
  localparam int HOLD_W         = 16;
  localparam int MAP_W          = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int Q_DEPTH        = 2;
  localparam int Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_START    = 3'd1,
    MODE_ENTER    = 3'd2,
    MODE_BACK     = 3'd3,
    MODE_SAVE_ACK = 3'd4
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DB_ROLL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DB_PITCH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DB_THROTTLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DB_YAW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DONE_HOLD    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CANCEL_HOLD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS      = 3'd7;

  localparam logic [1:0] OUTCOME_NONE      = 2'd0;
  localparam logic [1:0] OUTCOME_SAVED     = 2'd1;
  localparam logic [1:0] OUTCOME_FAILED    = 2'd2;
  localparam logic [1:0] OUTCOME_CANCELLED = 2'd3;

  localparam logic [2:0] PHASE_CENTRE  = 3'd0;
  localparam logic [2:0] PHASE_CAPTURE = 3'd1;
  localparam logic [2:0] PHASE_EXTREME = 3'd2;
  localparam logic [2:0] PHASE_AWAIT   = 3'd3;
  localparam logic [2:0] PHASE_RESULT  = 3'd4;

  typedef enum logic [4:0] {
    PH_CENTRE  = 5'b00001,
    PH_CAPTURE = 5'b00010,
    PH_EXTREME = 5'b00100,
    PH_AWAIT   = 5'b01000,
    PH_RESULT  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [MAP_W-1:0]             channel_map;
    logic [NUM_CH-1:0][DB_W-1:0]  deadband;
    logic [HOLD_W-1:0]            done_hold;
    logic [HOLD_W-1:0]            cancel_hold;
    logic [HOLD_W-1:0]            tick_ms;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] center;
    logic [SAMPLE_BITS-1:0] min_v;
    logic [SAMPLE_BITS-1:0] max_v;
    logic [DB_W-1:0]        db;
  } rec_t;

  typedef struct packed {
    logic                   is_rec;
    logic                   active;
    logic [2:0]             phase;
    logic [1:0]             outcome;
    rec_t [NUM_CH-1:0]      recs;
  } job_t;

  function automatic logic [2:0] phase_code(phase_e p);
    logic [2:0] c;
    case (p)
      PH_CENTRE:  c = PHASE_CENTRE;
      PH_CAPTURE: c = PHASE_CAPTURE;
      PH_EXTREME: c = PHASE_EXTREME;
      PH_AWAIT:   c = PHASE_AWAIT;
      PH_RESULT:  c = PHASE_RESULT;
      default:    c = PHASE_CENTRE;
    endcase
    return c;
  endfunction

endpackage

[sv/jcs_front.sv]
// jcs_front: accepts words, runs the calibration state and builds one job per word.
// Depends on jcs_pkg.
module jcs_front (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  jcs_pkg::cfg_t                             cfg,
  input  logic                                      accept,
  input  logic [2:0]                                mode,
  input  logic [jcs_pkg::NUM_CH-1:0][jcs_pkg::SAMPLE_BITS-1:0] raw,
  input  logic                                      save_ok,
  output jcs_pkg::job_t                             job
);

  logic                                        running_r, running_nxt;
  jcs_pkg::phase_e                             phase_r, phase_nxt;
  logic [1:0]                                  outcome_r, outcome_nxt;
  logic [jcs_pkg::HOLD_W-1:0]                  hold_r, hold_nxt;
  logic [jcs_pkg::CNT_W-1:0]                   count_r, count_nxt;
  logic [jcs_pkg::NUM_CH-1:0][jcs_pkg::SUM_W-1:0] sum_r, sum_nxt;
  jcs_pkg::rec_t [jcs_pkg::NUM_CH-1:0]         chan_r, chan_nxt;
  logic                                        is_rec;

  always_comb begin
    logic [jcs_pkg::CH_W-1:0]                    ch;
    logic [jcs_pkg::CNT_W-1:0]                   cnt_inc;
    logic [jcs_pkg::NUM_CH-1:0][jcs_pkg::SUM_W-1:0] sum_add;
    logic [jcs_pkg::SAMPLE_BITS-1:0]             mean;
    ch          = '0;
    mean        = '0;
    running_nxt = running_r;
    phase_nxt   = phase_r;
    outcome_nxt = outcome_r;
    hold_nxt    = hold_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    chan_nxt    = chan_r;
    is_rec      = 1'b0;
    cnt_inc     = count_r + 1'b1;
    for (int r = 0; r < jcs_pkg::NUM_CH; r++) begin
      sum_add[r] = sum_r[r] + jcs_pkg::SUM_W'(raw[r]);
    end
    case (jcs_pkg::mode_e'(mode))
      jcs_pkg::MODE_START: begin
        running_nxt = 1'b1;
        phase_nxt   = jcs_pkg::PH_CENTRE;
        outcome_nxt = jcs_pkg::OUTCOME_NONE;
        hold_nxt    = '0;
        count_nxt   = '0;
        sum_nxt     = '0;
      end
      jcs_pkg::MODE_TICK: begin
        if (running_r) begin
          case (phase_r)
            jcs_pkg::PH_CAPTURE: begin
              if (cnt_inc == jcs_pkg::CNT_W'(jcs_pkg::CENTER_SAMPLES)) begin
                for (int r = 0; r < jcs_pkg::NUM_CH; r++) begin
                  ch   = cfg.channel_map[jcs_pkg::CH_W*r +: jcs_pkg::CH_W];
                  mean = jcs_pkg::SAMPLE_BITS'(sum_add[r] / jcs_pkg::CENTER_SAMPLES);
                  chan_nxt[ch].center = mean;
                  chan_nxt[ch].min_v  = mean;
                  chan_nxt[ch].max_v  = mean;
                  chan_nxt[ch].db     = cfg.deadband[ch];
                end
                count_nxt = '0;
                sum_nxt   = '0;
                phase_nxt = jcs_pkg::PH_EXTREME;
              end else begin
                count_nxt = cnt_inc;
                sum_nxt   = sum_add;
              end
            end
            jcs_pkg::PH_EXTREME: begin
              for (int r = 0; r < jcs_pkg::NUM_CH; r++) begin
                ch = cfg.channel_map[jcs_pkg::CH_W*r +: jcs_pkg::CH_W];
                if (raw[r] < chan_nxt[ch].min_v) chan_nxt[ch].min_v = raw[r];
                if (raw[r] > chan_nxt[ch].max_v) chan_nxt[ch].max_v = raw[r];
              end
            end
            jcs_pkg::PH_RESULT: begin
              if (hold_r > cfg.tick_ms) begin
                hold_nxt = hold_r - cfg.tick_ms;
              end else begin
                running_nxt = 1'b0;
                phase_nxt   = jcs_pkg::PH_CENTRE;
                outcome_nxt = jcs_pkg::OUTCOME_NONE;
                hold_nxt    = '0;
              end
            end
            default: ;
          endcase
        end
      end
      jcs_pkg::MODE_BACK: begin
        if (running_r && phase_r != jcs_pkg::PH_RESULT) begin
          phase_nxt   = jcs_pkg::PH_RESULT;
          outcome_nxt = jcs_pkg::OUTCOME_CANCELLED;
          hold_nxt    = cfg.cancel_hold;
        end
      end
      jcs_pkg::MODE_ENTER: begin
        if (running_r && phase_r == jcs_pkg::PH_CENTRE) begin
          count_nxt = '0;
          sum_nxt   = '0;
          phase_nxt = jcs_pkg::PH_CAPTURE;
        end else if (running_r && phase_r == jcs_pkg::PH_EXTREME) begin
          phase_nxt = jcs_pkg::PH_AWAIT;
          is_rec    = 1'b1;
        end
      end
      jcs_pkg::MODE_SAVE_ACK: begin
        if (running_r && phase_r == jcs_pkg::PH_AWAIT) begin
          phase_nxt   = jcs_pkg::PH_RESULT;
          outcome_nxt = save_ok ? jcs_pkg::OUTCOME_SAVED : jcs_pkg::OUTCOME_FAILED;
          hold_nxt    = cfg.done_hold;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    job.is_rec  = is_rec;
    job.active  = running_nxt;
    job.phase   = jcs_pkg::phase_code(phase_nxt);
    job.outcome = outcome_nxt;
    job.recs    = chan_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      phase_r   <= jcs_pkg::PH_CENTRE;
      outcome_r <= jcs_pkg::OUTCOME_NONE;
      hold_r    <= '0;
      count_r   <= '0;
      sum_r     <= '0;
    end else if (accept) begin
      running_r <= running_nxt;
      phase_r   <= phase_nxt;
      outcome_r <= outcome_nxt;
      hold_r    <= hold_nxt;
      count_r   <= count_nxt;
      sum_r     <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r <= chan_nxt;
    end
  end

endmodule

[sv/jcs_queue.sv]
// jcs_queue: short job queue between front and back.
// Depends on jcs_pkg.
module jcs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  jcs_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output jcs_pkg::job_t rd_job,
  output logic          empty
);

  jcs_pkg::job_t                mem_r [jcs_pkg::Q_DEPTH];
  logic [jcs_pkg::Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [jcs_pkg::Q_CNT_W-1:0]  cnt_r;
  logic                         do_wr, do_rd;

  assign full   = cnt_r == jcs_pkg::Q_CNT_W'(jcs_pkg::Q_DEPTH);
  assign empty  = cnt_r == '0;
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == jcs_pkg::Q_PTR_W'(jcs_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == jcs_pkg::Q_PTR_W'(jcs_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

[sv/jcs_back.sv]
// jcs_back: takes queued jobs and presents one result word per cycle on pop.
// Depends on jcs_pkg.
module jcs_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  jcs_pkg::job_t                    q_job,
  output logic                             q_pop,
  input  logic                             pop,
  output logic                             empty,
  output logic                             out_active,
  output logic [2:0]                       out_phase,
  output logic [1:0]                       out_outcome,
  output logic                             out_record_valid,
  output logic [jcs_pkg::CH_W-1:0]         out_channel,
  output logic [jcs_pkg::SAMPLE_BITS-1:0]  out_center_value,
  output logic [jcs_pkg::SAMPLE_BITS-1:0]  out_min_value,
  output logic [jcs_pkg::SAMPLE_BITS-1:0]  out_max_value,
  output logic [jcs_pkg::DB_W-1:0]         out_deadband_value,
  output logic                             out_last
);

  jcs_pkg::job_t             job_r;
  logic                      valid_r;
  logic [jcs_pkg::CH_W-1:0]  idx_r;
  logic                      is_last, done_word, load;
  jcs_pkg::rec_t             rec;

  assign is_last   = !job_r.is_rec || idx_r == jcs_pkg::CH_W'(jcs_pkg::NUM_CH - 1);
  assign done_word = pop && valid_r && is_last;
  assign load      = !valid_r || done_word;
  assign q_pop     = load && !q_empty;
  assign rec       = job_r.is_rec ? job_r.recs[idx_r] : '0;

  assign empty              = !valid_r;
  assign out_active         = job_r.active;
  assign out_phase          = job_r.phase;
  assign out_outcome        = job_r.outcome;
  assign out_record_valid   = job_r.is_rec;
  assign out_channel        = job_r.is_rec ? idx_r : '0;
  assign out_center_value   = rec.center;
  assign out_min_value      = rec.min_v;
  assign out_max_value      = rec.max_v;
  assign out_deadband_value = rec.db;
  assign out_last           = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= !q_empty;
      idx_r   <= '0;
    end else if (pop) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
  end

endmodule

[sv/joystick_calibration_sequencer.sv]
// joystick_calibration_sequencer: top level, configuration registers and the
// front, queue and back parts. Depends on jcs_pkg, jcs_front, jcs_queue, jcs_back.
// A result word passes through the queue entry and then the back end's job register.
// Throughput: one input word per cycle; an enter in the extremes phase gives four result
// words, one per cycle while pop is held; input stalls once the two-entry queue fills.
// Reset (synchronous, rst_n low): flow idle, queue and output empty, registers at defaults.
module joystick_calibration_sequencer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic [2:0]                           in_mode,
  input  logic [jcs_pkg::SAMPLE_BITS-1:0]      in_raw_a,
  input  logic [jcs_pkg::SAMPLE_BITS-1:0]      in_raw_b,
  input  logic [jcs_pkg::SAMPLE_BITS-1:0]      in_raw_c,
  input  logic [jcs_pkg::SAMPLE_BITS-1:0]      in_raw_d,
  input  logic                                 in_save_ok,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 out_active,
  output logic [2:0]                           out_phase,
  output logic [1:0]                           out_outcome,
  output logic                                 out_record_valid,
  output logic [jcs_pkg::CH_W-1:0]             out_channel,
  output logic [jcs_pkg::SAMPLE_BITS-1:0]      out_center_value,
  output logic [jcs_pkg::SAMPLE_BITS-1:0]      out_min_value,
  output logic [jcs_pkg::SAMPLE_BITS-1:0]      out_max_value,
  output logic [jcs_pkg::DB_W-1:0]             out_deadband_value,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [jcs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jcs_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  jcs_pkg::cfg_t  cfg_r;
  jcs_pkg::job_t  front_job, q_job;
  logic           accept, q_empty, q_pop;
  logic [jcs_pkg::NUM_CH-1:0][jcs_pkg::SAMPLE_BITS-1:0] raw;

  assign accept = push && !full;
  assign raw    = {in_raw_d, in_raw_c, in_raw_b, in_raw_a};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_map <= 8'd228;
      cfg_r.deadband    <= {8'd15, 8'd0, 8'd15, 8'd15};
      cfg_r.done_hold   <= 16'd1200;
      cfg_r.cancel_hold <= 16'd800;
      cfg_r.tick_ms     <= 16'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        jcs_pkg::REG_CHANNEL_MAP: cfg_r.channel_map <= cfg_wdata[jcs_pkg::MAP_W-1:0];
        jcs_pkg::REG_DB_ROLL:     cfg_r.deadband[0] <= cfg_wdata[jcs_pkg::DB_W-1:0];
        jcs_pkg::REG_DB_PITCH:    cfg_r.deadband[1] <= cfg_wdata[jcs_pkg::DB_W-1:0];
        jcs_pkg::REG_DB_THROTTLE: cfg_r.deadband[2] <= cfg_wdata[jcs_pkg::DB_W-1:0];
        jcs_pkg::REG_DB_YAW:      cfg_r.deadband[3] <= cfg_wdata[jcs_pkg::DB_W-1:0];
        jcs_pkg::REG_DONE_HOLD:   cfg_r.done_hold   <= cfg_wdata[jcs_pkg::HOLD_W-1:0];
        jcs_pkg::REG_CANCEL_HOLD: cfg_r.cancel_hold <= cfg_wdata[jcs_pkg::HOLD_W-1:0];
        jcs_pkg::REG_TICK_MS:     cfg_r.tick_ms     <= cfg_wdata[jcs_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  jcs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .mode    (in_mode),
    .raw     (raw),
    .save_ok (in_save_ok),
    .job     (front_job)
  );

  jcs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_job (front_job),
    .full   (full),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  jcs_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_job              (q_job),
    .q_pop              (q_pop),
    .pop                (pop),
    .empty              (empty),
    .out_active         (out_active),
    .out_phase          (out_phase),
    .out_outcome        (out_outcome),
    .out_record_valid   (out_record_valid),
    .out_channel        (out_channel),
    .out_center_value   (out_center_value),
    .out_min_value      (out_min_value),
    .out_max_value      (out_max_value),
    .out_deadband_value (out_deadband_value),
    .out_last           (out_last)
  );

`ifndef SYNTHESIS
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_status_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_record_valid) |-> (out_last && out_channel == '0))
    else $error("status word with record fields or without last");

  a_record_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_record_valid) |->
      (out_last == (out_channel == jcs_pkg::CH_W'(jcs_pkg::NUM_CH - 1))))
    else $error("record last flag out of step with channel");

  a_record_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_record_valid && !out_last) |=>
      (!empty && out_record_valid && out_channel == $past(out_channel) + 1'b1))
    else $error("record words not in channel order");
`endif

endmodule

[sim/joystick_calibration_sequencer_tb.sv]
// joystick_calibration_sequencer_tb: self-checking bench for the calibration sequencer.
// Pushes words with random gaps, predicts each result word and checks it on pop.
// Depends on jcs_pkg and joystick_calibration_sequencer.
module joystick_calibration_sequencer_tb;
  import jcs_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int MAX_GAP       = 5;
  localparam int SETTLE_CYCLES = 4;
  localparam int LIMIT_CYCLES  = 250000;
  localparam int MAX_REPORTS   = 100;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [SAMPLE_BITS-1:0] S_MAX = '1;

  typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] samples_t;

  typedef struct {
    logic                   active;
    logic [2:0]             phase;
    logic [1:0]             outcome;
    logic                   rec;
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_BITS-1:0] centre;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [DB_W-1:0]        db;
    logic                   last;
  } word_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   push       = 1'b0;
  logic                   full;
  logic [2:0]             in_mode    = '0;
  logic [SAMPLE_BITS-1:0] in_raw_a   = '0;
  logic [SAMPLE_BITS-1:0] in_raw_b   = '0;
  logic [SAMPLE_BITS-1:0] in_raw_c   = '0;
  logic [SAMPLE_BITS-1:0] in_raw_d   = '0;
  logic                   in_save_ok = 1'b0;
  logic                   empty;
  logic                   pop        = 1'b0;
  logic                   out_active;
  logic [2:0]             out_phase;
  logic [1:0]             out_outcome;
  logic                   out_record_valid;
  logic [CH_W-1:0]        out_channel;
  logic [SAMPLE_BITS-1:0] out_center_value;
  logic [SAMPLE_BITS-1:0] out_min_value;
  logic [SAMPLE_BITS-1:0] out_max_value;
  logic [DB_W-1:0]        out_deadband_value;
  logic                   out_last;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  joystick_calibration_sequencer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_mode            (in_mode),
    .in_raw_a           (in_raw_a),
    .in_raw_b           (in_raw_b),
    .in_raw_c           (in_raw_c),
    .in_raw_d           (in_raw_d),
    .in_save_ok         (in_save_ok),
    .empty              (empty),
    .pop                (pop),
    .out_active         (out_active),
    .out_phase          (out_phase),
    .out_outcome        (out_outcome),
    .out_record_valid   (out_record_valid),
    .out_channel        (out_channel),
    .out_center_value   (out_center_value),
    .out_min_value      (out_min_value),
    .out_max_value      (out_max_value),
    .out_deadband_value (out_deadband_value),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // register copies
  logic [MAP_W-1:0]       map_q;
  logic [DB_W-1:0]        band_cfg [NUM_CH];
  logic [HOLD_W-1:0]      done_hold_q, cancel_hold_q, tick_step_q;

  // flow state copies
  logic                   flow_on;
  logic [2:0]             flow_phase;
  logic [1:0]             flow_outcome;
  logic [HOLD_W-1:0]      hold_left;
  int                     grab_count;
  logic [SUM_W-1:0]       grab_sum [NUM_CH];
  logic [SAMPLE_BITS-1:0] ctr_q [NUM_CH];
  logic [SAMPLE_BITS-1:0] lo_q [NUM_CH];
  logic [SAMPLE_BITS-1:0] hi_q [NUM_CH];
  logic [DB_W-1:0]        band_q [NUM_CH];
  bit   [NUM_CH-1:0]      seen_ch;

  word_t pending_words[$];
  int    errors          = 0;
  int    effective_words = 0;
  bit    no_stall        = 1'b0;

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(input string msg);
    if (errors < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic word_t status_word();
    word_t w;
    w.active  = flow_on;
    w.phase   = flow_phase;
    w.outcome = flow_outcome;
    w.rec     = 1'b0;
    w.ch      = '0;
    w.centre  = '0;
    w.lo      = '0;
    w.hi      = '0;
    w.db      = '0;
    w.last    = 1'b1;
    return w;
  endfunction

  function automatic word_t record_word(input int k);
    word_t w;
    w         = status_word();
    w.rec     = 1'b1;
    w.ch      = CH_W'(k);
    w.centre  = ctr_q[k];
    w.lo      = lo_q[k];
    w.hi      = hi_q[k];
    w.db      = band_q[k];
    w.last    = (k == NUM_CH - 1);
    return w;
  endfunction

  task automatic advance_sequencer(input logic [2:0] mode, input samples_t raw,
                                   input logic ok, output bit effect);
    int r;
    logic [CH_W-1:0] ch;
    effect = 1'b0;
    if (mode == MODE_START) begin
      flow_on      = 1'b1;
      flow_phase   = PHASE_CENTRE;
      flow_outcome = OUTCOME_NONE;
      hold_left    = '0;
      grab_count   = 0;
      foreach (grab_sum[i]) grab_sum[i] = '0;
      effect = 1'b1;
    end else if (flow_on) begin
      if (mode == MODE_TICK) begin
        case (flow_phase)
          PHASE_CAPTURE: begin
            effect = 1'b1;
            for (r = 0; r < NUM_CH; r++) grab_sum[r] += SUM_W'(raw[r]);
            grab_count++;
            if (grab_count >= CENTER_SAMPLES) begin
              for (r = 0; r < NUM_CH; r++) begin
                ch         = map_q[2*r +: 2];
                ctr_q[ch]  = SAMPLE_BITS'(grab_sum[r] / CENTER_SAMPLES);
                lo_q[ch]   = ctr_q[ch];
                hi_q[ch]   = ctr_q[ch];
                band_q[ch] = band_cfg[ch];
                seen_ch[ch] = 1'b1;
              end
              grab_count = 0;
              foreach (grab_sum[i]) grab_sum[i] = '0;
              flow_phase = PHASE_EXTREME;
            end
          end
          PHASE_EXTREME: begin
            effect = 1'b1;
            for (r = 0; r < NUM_CH; r++) begin
              ch = map_q[2*r +: 2];
              if (raw[r] < lo_q[ch]) lo_q[ch] = raw[r];
              if (raw[r] > hi_q[ch]) hi_q[ch] = raw[r];
            end
          end
          PHASE_RESULT: begin
            effect = 1'b1;
            if (hold_left > tick_step_q) begin
              hold_left -= tick_step_q;
            end else begin
              flow_on      = 1'b0;
              flow_phase   = PHASE_CENTRE;
              flow_outcome = OUTCOME_NONE;
              hold_left    = '0;
            end
          end
          default: ;
        endcase
      end else if (flow_phase != PHASE_RESULT) begin
        if (mode == MODE_BACK) begin
          effect       = 1'b1;
          flow_phase   = PHASE_RESULT;
          flow_outcome = OUTCOME_CANCELLED;
          hold_left    = cancel_hold_q;
        end else if (mode == MODE_ENTER) begin
          if (flow_phase == PHASE_CENTRE) begin
            effect     = 1'b1;
            grab_count = 0;
            foreach (grab_sum[i]) grab_sum[i] = '0;
            flow_phase = PHASE_CAPTURE;
          end else if (flow_phase == PHASE_EXTREME) begin
            effect     = 1'b1;
            flow_phase = PHASE_AWAIT;
            for (r = 0; r < NUM_CH; r++) pending_words.push_back(record_word(r));
            return;
          end
        end else if (mode == MODE_SAVE_ACK && flow_phase == PHASE_AWAIT) begin
          effect       = 1'b1;
          flow_phase   = PHASE_RESULT;
          flow_outcome = ok ? OUTCOME_SAVED : OUTCOME_FAILED;
          hold_left    = done_hold_q;
        end
      end
    end
    pending_words.push_back(status_word());
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return S_MAX;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [2:0] mode, input logic [SAMPLE_BITS-1:0] a,
                           input logic [SAMPLE_BITS-1:0] b, input logic [SAMPLE_BITS-1:0] c,
                           input logic [SAMPLE_BITS-1:0] d, input logic ok);
    int gap;
    bit effect;
    logic [2:0] m;
    samples_t raw;
    gap = no_stall ? 0 : $urandom_range(0, MAX_GAP);
    raw = {d, c, b, a};
    m   = mode;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    // never read back a channel that no capture has written yet
    if (m == MODE_ENTER && flow_on && flow_phase == PHASE_EXTREME && !(&seen_ch))
      m = MODE_TICK;
    push       <= 1'b1;
    in_mode    <= m;
    in_raw_a   <= a;
    in_raw_b   <= b;
    in_raw_c   <= c;
    in_raw_d   <= d;
    in_save_ok <= ok;
    do @(posedge clk); while (full);
    advance_sequencer(m, raw, ok, effect);
    if (effect) effective_words++;
  endtask

  task automatic send_op(input logic [2:0] mode);
    send_word(mode, rand_sample(), rand_sample(), rand_sample(), rand_sample(), 1'($urandom));
  endtask

  task automatic send_tick(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b,
                           input logic [SAMPLE_BITS-1:0] c, input logic [SAMPLE_BITS-1:0] d);
    send_word(MODE_TICK, a, b, c, d, 1'($urandom));
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_CHANNEL_MAP: map_q         = data[MAP_W-1:0];
      REG_DB_ROLL:     band_cfg[0]   = data[DB_W-1:0];
      REG_DB_PITCH:    band_cfg[1]   = data[DB_W-1:0];
      REG_DB_THROTTLE: band_cfg[2]   = data[DB_W-1:0];
      REG_DB_YAW:      band_cfg[3]   = data[DB_W-1:0];
      REG_DONE_HOLD:   done_hold_q   = data;
      REG_CANCEL_HOLD: cancel_hold_q = data;
      REG_TICK_MS:     tick_step_q   = data;
      default: ;
    endcase
  endtask

  // upper bits of the 8-bit registers get noise; they must be dropped
  task automatic load_registers(input logic [7:0] map, input logic [7:0] db0,
                                input logic [7:0] db1, input logic [7:0] db2,
                                input logic [7:0] db3, input logic [15:0] done_hold,
                                input logic [15:0] cancel_hold, input logic [15:0] tick);
    drain_results();
    write_reg(REG_CHANNEL_MAP, {8'($urandom), map});
    write_reg(REG_DB_ROLL,     {8'($urandom), db0});
    write_reg(REG_DB_PITCH,    {8'($urandom), db1});
    write_reg(REG_DB_THROTTLE, {8'($urandom), db2});
    write_reg(REG_DB_YAW,      {8'($urandom), db3});
    write_reg(REG_DONE_HOLD,   done_hold);
    write_reg(REG_CANCEL_HOLD, cancel_hold);
    write_reg(REG_TICK_MS,     tick);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  task automatic check_word();
    word_t want;
    if (pending_words.size() == 0) begin
      report($sformatf("word with nothing expected (phase %0d, last %0b)", out_phase, out_last));
      return;
    end
    want = pending_words.pop_front();
    check_field("active",         16'(out_active),         16'(want.active));
    check_field("phase",          16'(out_phase),          16'(want.phase));
    check_field("outcome",        16'(out_outcome),        16'(want.outcome));
    check_field("record_valid",   16'(out_record_valid),   16'(want.rec));
    check_field("channel",        16'(out_channel),        16'(want.ch));
    check_field("center_value",   16'(out_center_value),   16'(want.centre));
    check_field("min_value",      16'(out_min_value),      16'(want.lo));
    check_field("max_value",      16'(out_max_value),      16'(want.hi));
    check_field("deadband_value", 16'(out_deadband_value), 16'(want.db));
    check_field("last",           16'(out_last),           16'(want.last));
  endtask

  initial begin : result_side
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_word();
    end
  end

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0)
      send_word(3'($urandom), SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 1'($urandom));
  endtask

  task automatic random_session();
    int n;
    if ($urandom_range(0, 9) == 0) no_stall = ~no_stall;
    send_op(MODE_START);
    maybe_noise();
    if ($urandom_range(0, 9) != 0) begin
      send_op(MODE_ENTER);
      repeat (CENTER_SAMPLES) begin
        send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        maybe_noise();
      end
      n = $urandom_range(0, 6);
      repeat (n) begin
        send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        maybe_noise();
      end
      send_op(MODE_ENTER);
      maybe_noise();
    end
    if ($urandom_range(0, 7) == 0) send_op(MODE_BACK);
    else send_op(MODE_SAVE_ACK);
    n = $urandom_range(0, 30);
    repeat (n) begin
      send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
      maybe_noise();
      if (!flow_on) break;
    end
  endtask

  task automatic run_random(input int count);
    int first;
    first = effective_words;
    while (effective_words - first < count) random_session();
  endtask

  task automatic test_idle_ignored();
    send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    send_op(MODE_ENTER);
    send_op(MODE_SAVE_ACK);
    send_op(MODE_SPARE_LO);
    send_op(MODE_SPARE_HI);
  endtask

  task automatic test_capture_and_records();
    int i;
    send_op(MODE_START);
    send_op(MODE_ENTER);
    send_op(MODE_ENTER);
    for (i = 0; i < CENTER_SAMPLES; i++)
      send_tick(S_MAX, '0, (i % 2) ? S_MAX : '0, rand_sample());
    send_tick('0, S_MAX, rand_sample(), rand_sample());
    send_op(MODE_ENTER);
  endtask

  task automatic test_save_and_cancel();
    send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    send_op(MODE_ENTER);
    send_word(MODE_SAVE_ACK, rand_sample(), rand_sample(), rand_sample(), rand_sample(), 1'b0);
    send_op(MODE_BACK);
    send_op(MODE_SAVE_ACK);
    send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    send_op(MODE_START);
    send_op(MODE_BACK);
  endtask

  task automatic test_duplicate_map_zero_tick();
    load_registers({2'd1, 2'd1, 2'd0, 2'd0}, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 16'd100, 16'd0, 16'd0);
    send_op(MODE_START);
    send_op(MODE_ENTER);
    repeat (CENTER_SAMPLES) send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    send_op(MODE_ENTER);
    send_word(MODE_SAVE_ACK, rand_sample(), rand_sample(), rand_sample(), rand_sample(), 1'b1);
    send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    send_op(MODE_START);
    send_op(MODE_BACK);
    send_tick(rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  task automatic test_random_default();
    drain_results();
    run_random(55);
  endtask

  task automatic test_random_maximum();
    load_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(45);
  endtask

  task automatic test_random_minimum();
    load_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0001);
    run_random(45);
  endtask

  task automatic test_random_mixed();
    repeat (2) begin
      load_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                     16'($urandom_range(1, 60)));
      run_random(45);
    end
  endtask

  initial begin
    map_q         = 8'd228;
    band_cfg[0]   = 8'd15;
    band_cfg[1]   = 8'd15;
    band_cfg[2]   = 8'd0;
    band_cfg[3]   = 8'd15;
    done_hold_q   = 16'd1200;
    cancel_hold_q = 16'd800;
    tick_step_q   = 16'd50;
    flow_on       = 1'b0;
    flow_phase    = PHASE_CENTRE;
    flow_outcome  = OUTCOME_NONE;
    hold_left     = '0;
    grab_count    = 0;
    seen_ch       = '0;
    foreach (grab_sum[i]) grab_sum[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ignored();
    test_capture_and_records();
    test_save_and_cancel();
    test_random_default();
    test_duplicate_map_zero_tick();
    test_random_maximum();
    test_random_minimum();
    test_random_mixed();

    drain_results();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
